FILE: sv/itoa_pkg.sv
// shared types and constants for the integer to ascii formatter
// used by itoa_ctrl, itoa_dp and integer_to_ascii_formatter; no dependencies
package itoa_pkg;

   localparam int MAX_CHARS_DEF = 31;
   localparam int DIGITS = 20;
   localparam int DIGIT_BITS = 4 * DIGITS;
   localparam int ND_W = 5;
   localparam int BIT_CNT_W = 6;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_A = 8'h61;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef struct packed {
      logic load;
      logic dabble;
      logic norm;
      logic calc_pad;
      logic emit_sign;
      logic emit_pad;
      logic emit_digit;
   } cmd_type;

   typedef struct packed {
      logic hex;
      logic neg;
      logic bits_last;
      logic norm_done;
      logic pad_empty;
      logic digit_last;
      logic out_free;
   } status_type;

endpackage

FILE: sv/itoa_ctrl.sv
// controller state machine of the integer to ascii formatter
// depends on itoa_pkg for the command and status structs
module itoa_ctrl
   import itoa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONVERT = 3'd1;
   localparam logic [2:0] ST_NORM = 3'd2;
   localparam logic [2:0] ST_SIGN = 3'd3;
   localparam logic [2:0] ST_PAD = 3'd4;
   localparam logic [2:0] ST_DIGIT = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (status.hex) begin
               state_in = ST_NORM;
            end else begin
               cmd.dabble = 1'b1;
               if (status.bits_last) state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (status.norm_done) begin
               cmd.calc_pad = 1'b1;
               state_in = status.neg ? ST_SIGN : ST_PAD;
            end else begin
               cmd.norm = 1'b1;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (status.pad_empty) begin
               state_in = ST_DIGIT;
            end else if (status.out_free) begin
               cmd.emit_pad = 1'b1;
            end
         end
         ST_DIGIT: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.digit_last) state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/itoa_dp.sv
// datapath of the integer to ascii formatter: magnitude, shift-add-3 digit
// conversion, leading zero removal, pad count and output register; uses itoa_pkg
module itoa_dp
   import itoa_pkg::*;
#(
   parameter int MAX_CHARS = MAX_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [63:0] value,
   input  logic        signed_mode,
   input  logic        hex_mode,
   input  logic        wide,
   input  logic        zero_pad,
   input  logic [4:0]  min_width,
   input  cmd_type     cmd,
   output status_type  status,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  out_char,
   output logic        last
);

   localparam int CNT_W = $clog2(MAX_CHARS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHARS);

   logic [63:0]            mag_ff, mag_in;
   logic [DIGIT_BITS-1:0]  dig_ff, dig_in;
   logic [ND_W-1:0]        nd_ff, nd_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [CNT_W-1:0]       pad_cnt_ff, pad_cnt_in;
   logic                   neg_ff, neg_in;
   logic                   hex_ff, hex_in;
   logic                   wide_ff, wide_in;
   logic                   zero_pad_ff, zero_pad_in;
   logic [4:0]             width_ff, width_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   load_neg;
   logic [63:0]            load_mag;
   logic [DIGIT_BITS-1:0]  adj;
   logic [DIGIT_BITS-1:0]  shifted;
   logic [3:0]             top;
   logic [7:0]             digit_char;
   logic [CNT_W-1:0]       fixed;
   logic [CNT_W-1:0]       width_ext;
   logic [CNT_W-1:0]       total;
   logic                   out_free;

   assign top = dig_ff[DIGIT_BITS-1 -: 4];
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (wide) begin
         load_neg = signed_mode && value[63];
         load_mag = load_neg ? (64'd0 - value) : value;
      end else begin
         load_neg = signed_mode && value[31];
         load_mag = {(load_neg ? (32'd0 - value[31:0]) : value[31:0]), 32'd0};
      end
   end

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         adj[4*i +: 4] = (dig_ff[4*i +: 4] >= 4'd5) ? (dig_ff[4*i +: 4] + 4'd3)
                                                     : dig_ff[4*i +: 4];
      end
      shifted = {adj[DIGIT_BITS-2:0], mag_ff[63]};
   end

   always_comb begin
      if (top >= 4'd10) digit_char = CHAR_A + {4'd0, top - 4'd10};
      else digit_char = CHAR_ZERO + {4'd0, top};
   end

   always_comb begin
      fixed = CNT_W'(nd_ff) + CNT_W'(neg_ff);
      width_ext = CNT_W'(width_ff);
      total = (width_ext > fixed) ? width_ext : fixed;
      if (total > MAX_CNT) total = MAX_CNT;
   end

   always_comb begin
      mag_in = mag_ff;
      dig_in = dig_ff;
      nd_in = nd_ff;
      bit_cnt_in = bit_cnt_ff;
      pad_cnt_in = pad_cnt_ff;
      neg_in = neg_ff;
      hex_in = hex_ff;
      wide_in = wide_ff;
      zero_pad_in = zero_pad_ff;
      width_in = width_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      if (cmd.load) begin
         neg_in = load_neg;
         hex_in = hex_mode;
         wide_in = wide;
         zero_pad_in = zero_pad;
         width_in = min_width;
         mag_in = load_mag;
         bit_cnt_in = wide ? BIT_CNT_W'(63) : BIT_CNT_W'(31);
         if (hex_mode) begin
            dig_in = {load_mag, 16'd0};
            nd_in = wide ? ND_W'(16) : ND_W'(8);
         end else begin
            dig_in = '0;
            nd_in = wide ? ND_W'(DIGITS) : ND_W'(DIGITS / 2);
         end
      end
      if (cmd.dabble) begin
         mag_in = {mag_ff[62:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - 1'b1;
         if (bit_cnt_ff == '0 && !wide_ff) dig_in = shifted << (DIGIT_BITS / 2);
         else dig_in = shifted;
      end
      if (cmd.norm) begin
         dig_in = dig_ff << 4;
         nd_in = nd_ff - 1'b1;
      end
      if (cmd.calc_pad) begin
         pad_cnt_in = total - fixed;
      end
      if (cmd.emit_sign) begin
         rsp_valid_in = 1'b1;
         rsp_char_in = CHAR_MINUS;
         rsp_last_in = 1'b0;
      end
      if (cmd.emit_pad) begin
         rsp_valid_in = 1'b1;
         rsp_char_in = zero_pad_ff ? CHAR_ZERO : CHAR_SPACE;
         rsp_last_in = 1'b0;
         pad_cnt_in = pad_cnt_ff - 1'b1;
      end
      if (cmd.emit_digit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in = digit_char;
         rsp_last_in = (nd_ff == ND_W'(1));
         dig_in = dig_ff << 4;
         nd_in = nd_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff <= mag_in;
      dig_ff <= dig_in;
      nd_ff <= nd_in;
      bit_cnt_ff <= bit_cnt_in;
      pad_cnt_ff <= pad_cnt_in;
      neg_ff <= neg_in;
      hex_ff <= hex_in;
      wide_ff <= wide_in;
      zero_pad_ff <= zero_pad_in;
      width_ff <= width_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      status.hex = hex_ff;
      status.neg = neg_ff;
      status.bits_last = (bit_cnt_ff == '0);
      status.norm_done = (top != 4'd0) || (nd_ff == ND_W'(1));
      status.pad_empty = (pad_cnt_ff == '0);
      status.digit_last = (nd_ff == ND_W'(1));
      status.out_free = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign out_char = rsp_char_ff;
   assign last = rsp_last_ff;

endmodule

FILE: sv/integer_to_ascii_formatter.sv
// top level of the integer to ascii formatter
// joins itoa_ctrl and itoa_dp; uses itoa_pkg
//
// Formats one 32- or 64-bit integer, signed or unsigned, in decimal or
// lower-case hex, and sends its ASCII characters most significant first,
// one transfer per character, with rsp_tlast on the final digit. A new
// number is taken only once the previous one has been fully handed to the
// output register. Per number: it is taken; then for decimal 32 or
// 64 value bits pass through shift-add-3 conversion (one value bit per
// cycle), while for hex the digits are loaded as they are; then leading
// zero nibbles are dropped (start of 10 or 20 decimal digits, 8 or 16 hex
// digits), keeping at least one digit; then the characters (sign, padding, digits)
// go out, holding while the output is stalled. Padding never lets the total exceed MAX_CHARS.
module integer_to_ascii_formatter
   import itoa_pkg::*;
#(
   parameter int MAX_CHARS = MAX_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // value
   input  logic [8:0]  req_tuser,  // signed_mode, hex_mode, wide, zero_pad, min_width[4:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // out_char
   output logic        rsp_tlast
);

   cmd_type    cmd;
   status_type status;

   itoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   itoa_dp #(
      .MAX_CHARS (MAX_CHARS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .value       (req_tdata),
      .signed_mode (req_tuser[0]),
      .hex_mode    (req_tuser[1]),
      .wide        (req_tuser[2]),
      .zero_pad    (req_tuser[3]),
      .min_width   (req_tuser[8:4]),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .out_char    (rsp_tdata),
      .last        (rsp_tlast)
   );

endmodule

FILE: tb/sv/tb_integer_to_ascii_formatter.sv
// self-checking testbench for integer_to_ascii_formatter
// needs all four rtl files of sv/; directed table, then random numbers
`timescale 1ns / 100ps

module tb_integer_to_ascii_formatter;

   localparam int CHAR_LIMIT = 31;
   localparam int RANDOM_NUMBERS = 95;
   localparam int DRAIN_CYCLES = 150;
   localparam int HOLD_AT_CHAR = 400;
   localparam int HOLD_CYCLES = 400;
   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_MINUS = 8'h2d;
   localparam logic [7:0] ASCII_SPACE = 8'h20;

   typedef struct packed {
      logic [63:0] value;
      logic        signed_mode;
      logic        hex_mode;
      logic        wide;
      logic        zero_pad;
      logic [4:0]  min_width;
   } number_req_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_exp_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;  // value
   logic [8:0]  req_tuser;  // signed_mode, hex_mode, wide, zero_pad, min_width[4:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;  // out_char
   logic        rsp_tlast;

   char_exp_type expected_chars[$];
   int           mismatch_count = 0;
   int           burst_left = 0;

   localparam int DIRECTED_ROWS = 25;

   number_req_type directed_rows[DIRECTED_ROWS] = '{
      '{64'h0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0},
      '{64'h0, 1'b0, 1'b0, 1'b0, 1'b1, 5'd5},
      '{64'h0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd5},
      '{64'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0},
      '{64'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 5'd0},
      '{64'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 5'd0},
      '{64'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 5'd0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b0, 5'd0},
      '{64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b1, 1'b0, 5'd0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0, 5'd0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b0, 5'd0},
      '{64'h8000_0000, 1'b1, 1'b1, 1'b0, 1'b0, 5'd0},
      '{64'hDEAD_BEEF, 1'b0, 1'b1, 1'b0, 1'b0, 5'd0},
      '{64'hFFFF_FFFF_0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0},
      '{64'h1234_5678_0000_002A, 1'b1, 1'b0, 1'b0, 1'b0, 5'd0},
      '{64'hFFFF_FFFB, 1'b1, 1'b0, 1'b0, 1'b1, 5'd6},
      '{64'hFFFF_FFFB, 1'b1, 1'b0, 1'b0, 1'b0, 5'd6},
      '{64'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b1, 5'd1},
      '{64'hFF, 1'b0, 1'b1, 1'b0, 1'b1, 5'd4},
      '{64'h0, 1'b0, 1'b1, 1'b1, 1'b1, 5'd31},
      '{64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b1, 1'b1, 5'd31},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b0, 5'd31},
      '{64'd1234567890, 1'b0, 1'b0, 1'b1, 1'b0, 5'd12},
      '{64'hFEDC_BA98_7654_3210, 1'b1, 1'b1, 1'b1, 1'b0, 5'd20},
      '{64'hABCD_0000_8765_4321, 1'b1, 1'b0, 1'b0, 1'b0, 5'd31}
   };

   // empty text: expectation comes from format_number
   string directed_text[DIRECTED_ROWS] = '{
      "0", "00000", "    0", "4294967295", "-1", "-2147483648", "2147483647",
      "18446744073709551615", "-9223372036854775808", "-1", "ffffffffffffffff",
      "-80000000", "deadbeef", "0", "42", "-00005", "-    5", "-1", "00ff",
      "", "", "", "", "", ""
   };

   integer_to_ascii_formatter #(
      .MAX_CHARS(CHAR_LIMIT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   function automatic void push_char(input logic [7:0] ch, input logic last);
      char_exp_type e;
      e.ch = ch;
      e.last = last;
      expected_chars.push_back(e);
   endfunction

   function automatic void push_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         push_char(text[i], i == text.len() - 1);
      end
   endfunction

   function automatic void format_number(input number_req_type r);
      logic [63:0] mag;
      logic [63:0] base;
      logic [63:0] d;
      logic        neg;
      logic [7:0]  digit_q[$];
      int          fixed;
      int          pad;
      int          total;
      int          k;
      neg = 1'b0;
      if (r.wide) begin
         mag = r.value;
         if (r.signed_mode && r.value[63]) begin
            neg = 1'b1;
            mag = 64'd0 - r.value;
         end
      end else begin
         mag = {32'd0, r.value[31:0]};
         if (r.signed_mode && r.value[31]) begin
            neg = 1'b1;
            mag = {32'd0, 32'd0 - r.value[31:0]};
         end
      end
      base = r.hex_mode ? 64'd16 : 64'd10;
      do begin
         d = mag % base;
         digit_q.push_front(d < 10 ? ASCII_ZERO + d[7:0] : ASCII_LOWER_A + d[7:0] - 8'd10);
         mag = mag / base;
      end while (mag != 0);
      fixed = digit_q.size() + (neg ? 1 : 0);
      pad = int'(r.min_width) - fixed;
      if (pad < 0) pad = 0;
      if (fixed + pad > CHAR_LIMIT) pad = (CHAR_LIMIT > fixed) ? CHAR_LIMIT - fixed : 0;
      total = fixed + pad;
      k = 0;
      if (neg) begin
         push_char(ASCII_MINUS, k == total - 1);
         k++;
      end
      for (int p = 0; p < pad; p++) begin
         push_char(r.zero_pad ? ASCII_ZERO : ASCII_SPACE, k == total - 1);
         k++;
      end
      foreach (digit_q[i]) begin
         push_char(digit_q[i], k == total - 1);
         k++;
      end
   endfunction

   function automatic number_req_type random_number();
      number_req_type r;
      int             sh;
      r.signed_mode = 1'($urandom_range(0, 1));
      r.hex_mode = 1'($urandom_range(0, 1));
      r.wide = 1'($urandom_range(0, 1));
      r.zero_pad = 1'($urandom_range(0, 1));
      r.min_width = 5'($urandom_range(0, 31));
      sh = $urandom_range(0, 63);
      case ($urandom_range(0, 4))
         0: r.value = {$urandom, $urandom};
         1: r.value = {$urandom, 32'($urandom_range(0, 999))};
         2: r.value = 64'd0 - 64'($urandom_range(1, 999));
         3: r.value = (64'd1 << sh) - 64'($urandom_range(0, 1));
         default: r.value = {$urandom, $urandom} >> sh;
      endcase
      return r;
   endfunction

   // expectations are queued when the number transfer is accepted
   task automatic send_number(input number_req_type r, input string text);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= r.value;
      req_tuser <= {r.min_width, r.zero_pad, r.wide, r.hex_mode, r.signed_mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (text.len() == 0) format_number(r);
      else push_text(text);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 5);
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver: checks each character transfer and stalls on its own pattern
   initial begin
      char_exp_type exp_char;
      int           rx_count;
      int           hold_left;
      int           pattern_age;
      logic [7:0]   stall_word;
      rx_count = 0;
      hold_left = 0;
      pattern_age = 0;
      stall_word = 8'hFF;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected transfer, expected none, actual char %h last %b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               exp_char = expected_chars.pop_front();
               if (rsp_tdata !== exp_char.ch) begin
                  mismatch_count++;
                  $display("%0t: out_char mismatch, expected %h actual %h",
                           $time, exp_char.ch, rsp_tdata);
               end
               if (rsp_tlast !== exp_char.last) begin
                  mismatch_count++;
                  $display("%0t: last mismatch, expected %b actual %b",
                           $time, exp_char.last, rsp_tlast);
               end
            end
            rx_count++;
            if (rx_count == HOLD_AT_CHAR) hold_left = HOLD_CYCLES;
         end
         if (pattern_age == 0) begin
            pattern_age = 32;
            stall_word = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
         end
         pattern_age--;
         stall_word = {stall_word[6:0], stall_word[7]};
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= stall_word[0];
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_number(directed_rows[i], directed_text[i]);
      end
      for (int i = 0; i < RANDOM_NUMBERS; i++) begin
         send_number(random_number(), "");
      end
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_integer_to_ascii_formatter passed");
      end else begin
         $display("tb_integer_to_ascii_formatter failed");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("tb_integer_to_ascii_formatter failed");
      $finish;
   end

endmodule
